// ===== src/acc_alu_pkg.sv =====
// types, operation codes and flag layout for the accumulator alu
// used by acc_alu_exec and accumulator_alu_with_flags; no dependencies
package acc_alu_pkg;

  localparam int CmdW = 5;

  localparam logic [CmdW-1:0] CMD_ADD  = 5'd0;
  localparam logic [CmdW-1:0] CMD_ADC  = 5'd1;
  localparam logic [CmdW-1:0] CMD_SUB  = 5'd2;
  localparam logic [CmdW-1:0] CMD_SBB  = 5'd3;
  localparam logic [CmdW-1:0] CMD_AND  = 5'd4;
  localparam logic [CmdW-1:0] CMD_XOR  = 5'd5;
  localparam logic [CmdW-1:0] CMD_OR   = 5'd6;
  localparam logic [CmdW-1:0] CMD_CMP  = 5'd7;
  localparam logic [CmdW-1:0] CMD_INR  = 5'd8;
  localparam logic [CmdW-1:0] CMD_DCR  = 5'd9;
  localparam logic [CmdW-1:0] CMD_DAA  = 5'd10;
  localparam logic [CmdW-1:0] CMD_RLC  = 5'd11;
  localparam logic [CmdW-1:0] CMD_RRC  = 5'd12;
  localparam logic [CmdW-1:0] CMD_RAL  = 5'd13;
  localparam logic [CmdW-1:0] CMD_RAR  = 5'd14;
  localparam logic [CmdW-1:0] CMD_PUSH = 5'd15;
  localparam logic [CmdW-1:0] CMD_POP  = 5'd16;

  // flag bit positions in the flags byte
  localparam int FlagCy = 0;
  localparam int FlagOne = 1;
  localparam int FlagP  = 2;
  localparam int FlagAc = 4;
  localparam int FlagZ  = 6;
  localparam int FlagS  = 7;

  localparam logic [7:0] DaaLowAdj  = 8'h06;
  localparam logic [7:0] DaaHighAdj = 8'h60;
  localparam logic [3:0] BcdMax     = 4'd9;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [7:0]      operand;
    logic [15:0]     psw_in;
  } in_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  flags_out;
    logic [7:0]  result_byte;
    logic [15:0] psw_word;
  } out_t;

  typedef struct packed {
    logic [7:0] acc;
    logic       cy;
    logic       p;
    logic       ac;
    logic       z;
    logic       s;
  } alu_state_t;

  function automatic logic [7:0] pack_flags(alu_state_t st);
    logic [7:0] f;
    f = 8'h00;
    f[FlagCy]  = st.cy;
    f[FlagOne] = 1'b1;
    f[FlagP]   = st.p;
    f[FlagAc]  = st.ac;
    f[FlagZ]   = st.z;
    f[FlagS]   = st.s;
    return f;
  endfunction

endpackage

// ===== src/accumulator_alu_with_flags.sv =====
// accumulator alu with carry, parity, aux carry, zero and sign flags
// an input transfer is captured in the item register, and its result in the output register
// throughput: one item per cycle while the output is not stalled; one 8-bit adder pass feeds state and result
// rate otherwise limited only by the input register to result register path
// reset: synchronous, clears accumulator, flags and both valid bits
// depends on acc_alu_pkg and acc_alu_exec
module accumulator_alu_with_flags
  import acc_alu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  in_t        item;
  logic       item_valid;
  alu_state_t state;
  alu_state_t state_next;
  logic [7:0] res_byte;
  logic       out_free;
  logic       advance;
  logic [7:0] flags_next;

  assign out_free = !out_valid || !out_stall;
  assign advance  = item_valid && out_free;
  assign in_stall = item_valid && !out_free;

  acc_alu_exec u_exec (
    .item     (item),
    .cur      (state),
    .nxt      (state_next),
    .res_byte (res_byte)
  );

  assign flags_next = pack_flags(state_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      item <= in_data;
    end
  end

  // state moves with the result register so results stay in order
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (out_free) begin
        out_valid <= item_valid;
      end
    end
    if (advance) begin
      out_data.acc_out     <= state_next.acc;
      out_data.flags_out   <= flags_next;
      out_data.result_byte <= res_byte;
      out_data.psw_word    <= {state_next.acc, flags_next};
    end
  end

`ifndef SYNTHESIS
  a_fixed_flag_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.flags_out[FlagOne] && !out_data.flags_out[3] &&
                   !out_data.flags_out[5]))
    else $error("fixed flag bits wrong");

  a_psw_packing: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.psw_word == {out_data.acc_out, out_data.flags_out}))
    else $error("psw word does not match accumulator and flags");

  a_state_matches_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.acc_out == state.acc &&
                   out_data.flags_out == pack_flags(state)))
    else $error("held result differs from state");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !out_free) |=> (item_valid && $stable(item)))
    else $error("pending item lost while output stalled");
`endif

endmodule

// ===== src/acc_alu_exec.sv =====
// single-pass operation logic: next accumulator and flags from one item
// depends on acc_alu_pkg
module acc_alu_exec
  import acc_alu_pkg::*;
(
  input  in_t        item,
  input  alu_state_t cur,
  output alu_state_t nxt,
  output logic [7:0] res_byte
);

  logic [7:0] add_b;
  logic       add_cin;
  logic [8:0] sum;
  logic [4:0] low;
  logic       adj_lo;
  logic       adj_hi;
  logic       is_sub;

  // decimal adjust decision from the current accumulator and flags
  always_comb begin
    adj_lo = (cur.acc[3:0] > BcdMax) || cur.ac;
    adj_hi = (cur.acc[7:4] > BcdMax) || cur.cy ||
             ((cur.acc[7:4] >= BcdMax) && (cur.acc[3:0] > BcdMax));
  end

  // one shared adder; subtract adds the complement with inverted carry in
  always_comb begin
    add_b   = item.operand;
    add_cin = 1'b0;
    is_sub  = 1'b0;
    case (item.cmd)
      CMD_ADC: add_cin = cur.cy;
      CMD_SUB, CMD_CMP: begin
        add_b   = ~item.operand;
        add_cin = 1'b1;
        is_sub  = 1'b1;
      end
      CMD_SBB: begin
        add_b   = ~item.operand;
        add_cin = ~cur.cy;
        is_sub  = 1'b1;
      end
      CMD_DAA: add_b = (adj_lo ? DaaLowAdj : 8'h00) | (adj_hi ? DaaHighAdj : 8'h00);
      default: ;
    endcase
    sum = {1'b0, cur.acc} + {1'b0, add_b} + {8'b0, add_cin};
    low = {1'b0, cur.acc[3:0]} + {1'b0, add_b[3:0]} + {4'b0, add_cin};
  end

  always_comb begin
    logic [7:0] zsp_v;
    logic       zsp_en;
    zsp_v    = sum[7:0];
    zsp_en   = 1'b0;
    nxt      = cur;
    res_byte = 8'h00;
    unique case (item.cmd)
      CMD_ADD, CMD_ADC, CMD_SUB, CMD_SBB, CMD_CMP: begin
        if (item.cmd != CMD_CMP) nxt.acc = sum[7:0];
        nxt.cy = sum[8] ^ is_sub;
        nxt.ac = low[4];
        zsp_en = 1'b1;
      end
      CMD_AND: begin
        nxt.acc = cur.acc & item.operand;
        nxt.ac  = cur.acc[3] | item.operand[3];
        nxt.cy  = 1'b0;
        zsp_v   = nxt.acc;
        zsp_en  = 1'b1;
      end
      CMD_XOR, CMD_OR: begin
        nxt.acc = (item.cmd == CMD_XOR) ? (cur.acc ^ item.operand)
                                        : (cur.acc | item.operand);
        nxt.cy  = 1'b0;
        nxt.ac  = 1'b0;
        zsp_v   = nxt.acc;
        zsp_en  = 1'b1;
      end
      CMD_INR: begin
        zsp_v  = item.operand + 8'd1;
        nxt.ac = (item.operand[3:0] == 4'hf);
        zsp_en = 1'b1;
      end
      CMD_DCR: begin
        zsp_v  = item.operand - 8'd1;
        nxt.ac = (item.operand[3:0] != 4'h0);
        zsp_en = 1'b1;
      end
      CMD_DAA: begin
        nxt.acc = sum[7:0];
        nxt.ac  = low[4];
        nxt.cy  = cur.cy | adj_hi;
        zsp_en  = 1'b1;
      end
      CMD_RLC: begin
        nxt.acc = {cur.acc[6:0], cur.acc[7]};
        nxt.cy  = cur.acc[7];
      end
      CMD_RRC: begin
        nxt.acc = {cur.acc[0], cur.acc[7:1]};
        nxt.cy  = cur.acc[0];
      end
      CMD_RAL: begin
        nxt.acc = {cur.acc[6:0], cur.cy};
        nxt.cy  = cur.acc[7];
      end
      CMD_RAR: begin
        nxt.acc = {cur.cy, cur.acc[7:1]};
        nxt.cy  = cur.acc[0];
      end
      CMD_POP: begin
        nxt.acc = item.psw_in[15:8];
        nxt.cy  = item.psw_in[FlagCy];
        nxt.p   = item.psw_in[FlagP];
        nxt.ac  = item.psw_in[FlagAc];
        nxt.z   = item.psw_in[FlagZ];
        nxt.s   = item.psw_in[FlagS];
      end
      default: ;  // push psw and unused codes leave the state alone
    endcase
    if (zsp_en) begin
      nxt.z = (zsp_v == 8'h00);
      nxt.s = zsp_v[7];
      nxt.p = ~(^zsp_v);
    end
    res_byte = (item.cmd == CMD_INR || item.cmd == CMD_DCR) ? zsp_v : nxt.acc;
  end

endmodule
